/* rtl/ihexp_pkg.sv */
// ----------------------------------------------------------------------------
// ihexp_pkg
// Shared types and codes for the hex record parser: result kinds, error
// codes and the result record passed from the engine to the output stage.
// ----------------------------------------------------------------------------
package ihexp_pkg;

  // Kind of one result item.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_OK     = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  // Error codes carried with an error result.
  typedef enum logic [1:0] {
    ERR_NONHEX = 2'd0,
    ERR_SUM    = 2'd1,
    ERR_END    = 2'd2,
    ERR_NONE   = 2'd3
  } err_t;

  // One result item as produced by the engine.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  record_type;
    logic [7:0]  byte_count;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [1:0]  error_code;
  } result_t;

endpackage

/* rtl/intel_hex_record_parser_core.sv */
// ----------------------------------------------------------------------------
// intel_hex_record_parser_core
// Path: an accepted character is taken into the input register, and its
// result is then taken into the result register and offered from there.
// Throughput: one character per cycle; the input stalls only while a result
// is held and the output side stalls.
// Reset: synchronous active-low rst_n returns to hunting for the start colon
// and clears all held record fields and both registers' valid flags.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_address,
  output logic [7:0]  out_record_type,
  output logic [7:0]  out_byte_count,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_data_index,
  output logic [1:0]  out_error_code
);
  import ihexp_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_ch_r;
  logic       in_eoi_r;
  logic       out_vld_r;
  result_t    out_r;
  logic       adv;
  logic       fire;
  logic       res_vld;
  result_t    res;

  // The processing step moves when the result register is free or draining.
  assign adv      = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_ch_r  <= in_character;
      in_eoi_r <= in_end_of_input;
    end
  end

  ihexp_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .ch      (in_ch_r),
    .eoi     (in_eoi_r),
    .res_vld (res_vld),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_kind        = out_r.kind;
  assign out_address     = out_r.address;
  assign out_record_type = out_r.record_type;
  assign out_byte_count  = out_r.byte_count;
  assign out_data_byte   = out_r.data_byte;
  assign out_data_index  = out_r.data_index;
  assign out_error_code  = out_r.error_code;

endmodule

/* rtl/ihexp_engine.sv */
// ----------------------------------------------------------------------------
// ihexp_engine
// Record state machine. Holds the parse state and, for each character that
// is processed, computes the next state and the result it causes (if any).
// ----------------------------------------------------------------------------
module ihexp_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        ch,
  input  logic              eoi,
  output logic              res_vld,
  output ihexp_pkg::result_t res
);
  import ihexp_pkg::*;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [3:0] LETTER_OFS = 4'd9;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_COUNT  = 3'd1,
    PH_ADDRHI = 3'd2,
    PH_ADDRLO = 3'd3,
    PH_TYPE   = 3'd4,
    PH_DATA   = 3'd5,
    PH_SUM    = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        second_r, second_nxt;
  logic [3:0]  high_r, high_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  done_r, done_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  type_r, type_nxt;

  logic        nib_ok;
  logic [3:0]  nib;
  logic [7:0]  byte_val;
  logic [7:0]  done_inc;
  logic        emit;
  kind_t       kind;
  logic [7:0]  dbyte;
  logic [7:0]  didx;
  err_t        err;

  // Hex digit decode; letters of either case map to 10..15.
  always_comb begin
    nib_ok = 1'b0;
    nib    = ch[3:0];
    if (ch >= CHAR_0 && ch <= CHAR_9) begin
      nib_ok = 1'b1;
    end else if ((ch >= CHAR_LA && ch <= CHAR_LF) || (ch >= CHAR_UA && ch <= CHAR_UF)) begin
      nib_ok = 1'b1;
      nib    = ch[3:0] + LETTER_OFS;
    end
    if (eoi) begin
      nib_ok = 1'b0;
    end
  end

  assign byte_val = {high_r, nib};
  assign done_inc = done_r + 8'd1;

  // Next state and result for the character being processed.
  always_comb begin
    phase_nxt  = phase_r;
    second_nxt = second_r;
    high_nxt   = high_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    done_nxt   = done_r;
    addr_nxt   = addr_r;
    type_nxt   = type_r;
    emit       = 1'b0;
    kind       = KIND_ERROR;
    dbyte      = 8'd0;
    didx       = 8'd0;
    err        = ERR_NONHEX;

    if (phase_r == PH_WAIT) begin
      // Hunting for the start colon.
      if (eoi) begin
        second_nxt = 1'b0;
        emit       = 1'b1;
        kind       = KIND_ERROR;
        err        = ERR_END;
      end else if (ch == CHAR_COLON) begin
        phase_nxt  = PH_COUNT;
        second_nxt = 1'b0;
        high_nxt   = 4'd0;
        sum_nxt    = 8'd0;
        done_nxt   = 8'd0;
      end
    end else if (!nib_ok) begin
      // Anything but a hex digit aborts the record.
      phase_nxt  = PH_WAIT;
      second_nxt = 1'b0;
      emit       = 1'b1;
      kind       = KIND_ERROR;
      err        = ERR_NONHEX;
    end else if (!second_r) begin
      high_nxt   = nib;
      second_nxt = 1'b1;
    end else begin
      // A full byte is complete.
      second_nxt = 1'b0;
      sum_nxt    = sum_r + byte_val;
      unique case (phase_r)
        PH_COUNT: begin
          count_nxt = byte_val;
          phase_nxt = PH_ADDRHI;
        end
        PH_ADDRHI: begin
          addr_nxt  = {byte_val, 8'd0};
          phase_nxt = PH_ADDRLO;
        end
        PH_ADDRLO: begin
          addr_nxt  = {addr_r[15:8], byte_val};
          phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          type_nxt  = byte_val;
          phase_nxt = (count_r != 8'd0) ? PH_DATA : PH_SUM;
          emit      = 1'b1;
          kind      = KIND_HEADER;
        end
        PH_DATA: begin
          done_nxt  = done_inc;
          if (done_inc >= count_r) begin
            phase_nxt = PH_SUM;
          end
          emit      = 1'b1;
          kind      = KIND_DATA;
          dbyte     = byte_val;
          didx      = done_r;
        end
        default: begin
          phase_nxt = PH_WAIT;
          emit      = 1'b1;
          if (sum_nxt != 8'd0) begin
            kind = KIND_ERROR;
            err  = ERR_SUM;
          end else begin
            kind = KIND_OK;
          end
        end
      endcase
    end
  end

  // Result record; held fields reflect this step's updates.
  always_comb begin
    res_vld          = fire && emit;
    res.kind         = kind;
    res.address      = addr_nxt;
    res.record_type  = type_nxt;
    res.byte_count   = count_nxt;
    res.data_byte    = dbyte;
    res.data_index   = didx;
    res.error_code   = (kind == KIND_ERROR) ? err : 2'd0;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      second_r <= 1'b0;
      high_r   <= 4'd0;
      sum_r    <= 8'd0;
      count_r  <= 8'd0;
      done_r   <= 8'd0;
      addr_r   <= 16'd0;
      type_r   <= 8'd0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      second_r <= second_nxt;
      high_r   <= high_nxt;
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
      done_r   <= done_nxt;
      addr_r   <= addr_nxt;
      type_r   <= type_nxt;
    end
  end

endmodule

/* rtl/ihexp_checker.sv */
// ----------------------------------------------------------------------------
// ihexp_checker
// Port-level checks for the hex record parser, bound to the top level.
// ----------------------------------------------------------------------------
module ihexp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_byte_count,
  input logic [7:0]  out_data_byte,
  input logic [7:0]  out_data_index,
  input logic [1:0]  out_error_code
);
  import ihexp_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Data byte and index are zero outside data results.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_data_byte == 8'd0 && out_data_index == 8'd0)
    else $error("data fields set outside a data result");

  // Error code is a defined code on errors and zero otherwise.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_ERROR) ? (out_error_code != ERR_NONE)
                                           : (out_error_code == 2'd0))
    else $error("bad error code");

  // A data index always lies inside the record's byte count.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> out_data_index < out_byte_count)
    else $error("data index beyond byte count");

  // No result is offered right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind intel_hex_record_parser_core ihexp_checker u_ihexp_checker (.*);

/* sim/tb_intel_hex_record_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_intel_hex_record_parser_core
// Self-checking bench for the hex record parser. A short table of characters
// walks the extremes, the four result kinds and every error path. Random
// records follow: most are well formed with random counts, addresses, types,
// data and digit case; the rest carry a bad checksum, a stray character, an
// early end or a cut-off tail, mixed with noise between records. A behavioral
// parser in the bench predicts each result, and a checker matches every
// output transfer against the oldest prediction while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ihexp_pkg::*;

  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_LO_A  = "a";
  localparam logic [7:0] CH_LO_F  = "f";
  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_UP_F  = "F";
  localparam result_t    NO_RESULT = '0;
  localparam int unsigned RANDOM_CHARS = 1500;

  // Where the bench parser is within a record.
  typedef enum logic [2:0] {
    SCAN_COLON,
    GET_COUNT,
    GET_ADDR_HI,
    GET_ADDR_LO,
    GET_TYPE,
    GET_DATA,
    GET_SUM
  } parse_phase_t;

  // Ways a random record gets damaged.
  typedef enum logic [1:0] {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_CHAR,
    FLAW_CUT
  } flaw_t;

  // One row of the directed table. Where given is set, want holds the
  // result typed in by hand (or no result when yields is clear).
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         given;
    bit         yields;
    result_t    want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_character = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [15:0] out_address;
  logic [7:0]  out_record_type;
  logic [7:0]  out_byte_count;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_data_index;
  logic [1:0]  out_error_code;

  // Bench copy of the parser state, starting from its reset values.
  parse_phase_t parse_phase = SCAN_COLON;
  bit           low_nibble_next = 1'b0;
  logic [3:0]   high_nib = 4'h0;
  logic [7:0]   run_sum = 8'h00;
  logic [7:0]   count_seen = 8'h00;
  logic [7:0]   data_seen = 8'h00;
  logic [15:0]  addr_seen = 16'h0000;
  logic [7:0]   type_seen = 8'h00;

  result_t     result_fifo[$];
  result_t     head_result;
  bit          calm = 1'b0;
  int unsigned stall_run = 0;
  int unsigned fail_count = 0;
  int unsigned chars_fed = 0;
  int unsigned record_chars = 0;
  int unsigned records_sent = 0;
  int unsigned results_seen = 0;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};

  // Directed walk: end before a record, skipped extremes, a data record with
  // a bad checksum, a zero-count record that checks out, then a colon and
  // an end of input inside a record.
  step_row_t directed_rows[30] = '{
    '{8'hFF, 1'b1, 1'b1, 1'b1, '{KIND_ERROR, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, ERR_END}},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
    '{":", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"1", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"F", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"f", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"9", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"A", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"a", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"F", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b1, 1'b1, '{KIND_ERROR, 16'hFF90, 8'hA0, 8'h01, 8'h00, 8'h00, ERR_SUM}},
    '{":", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"1", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"F", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"F", 1'b0, 1'b1, 1'b1, '{KIND_OK, 16'h0000, 8'h01, 8'h00, 8'h00, 8'h00, '0}},
    '{":", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{":", 1'b0, 1'b1, 1'b1, '{KIND_ERROR, 16'h0000, 8'h01, 8'h00, 8'h00, 8'h00, ERR_NONHEX}},
    '{":", 1'b0, 1'b0, 1'b0, NO_RESULT},
    '{"5", 1'b1, 1'b1, 1'b1, '{KIND_ERROR, 16'h0000, 8'h01, 8'h00, 8'h00, 8'h00, ERR_NONHEX}}
  };

  intel_hex_record_parser_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_character    (in_character),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_address     (out_address),
    .out_record_type (out_record_type),
    .out_byte_count  (out_byte_count),
    .out_data_byte   (out_data_byte),
    .out_data_index  (out_data_index),
    .out_error_code  (out_error_code)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decodes one hex digit in either case; returns 0 for anything else.
  function automatic bit hex_nibble(input logic [7:0] ch, output logic [3:0] nib);
    nib = 4'h0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      nib = 4'(ch - CH_ZERO);
      return 1'b1;
    end
    if (ch >= CH_LO_A && ch <= CH_LO_F) begin
      nib = 4'(ch - CH_LO_A + 8'd10);
      return 1'b1;
    end
    if (ch >= CH_UP_A && ch <= CH_UP_F) begin
      nib = 4'(ch - CH_UP_A + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Encodes a nibble as a hex digit, letters in random case.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_ZERO + 8'(nib);
    end
    return (($urandom_range(0, 1) == 0) ? CH_LO_A : CH_UP_A) + 8'(nib) - 8'd10;
  endfunction

  // Every result carries the held header fields.
  function automatic result_t with_held(input kind_t kind, input logic [7:0] dbyte,
                                        input logic [7:0] didx, input logic [1:0] code);
    result_t res;
    res.kind        = kind;
    res.address     = addr_seen;
    res.record_type = type_seen;
    res.byte_count  = count_seen;
    res.data_byte   = dbyte;
    res.data_index  = didx;
    res.error_code  = code;
    return res;
  endfunction

  // Advances the bench parser by one character; returns 1 when a result is due.
  function automatic bit parse_char(input logic [7:0] ch, input logic eoi, output result_t res);
    logic [3:0] nib;
    logic [7:0] val;
    bit         is_digit;
    res = NO_RESULT;

    // Outside a record only a colon or an end of input matters.
    if (parse_phase == SCAN_COLON) begin
      if (eoi) begin
        res = with_held(KIND_ERROR, '0, '0, ERR_END);
        return 1'b1;
      end
      if (ch == CH_COLON) begin
        parse_phase     = GET_COUNT;
        low_nibble_next = 1'b0;
        high_nib        = 4'h0;
        run_sum         = 8'h00;
        data_seen       = 8'h00;
      end
      return 1'b0;
    end

    // Inside a record, an end of input counts as a bad character.
    is_digit = hex_nibble(ch, nib);
    if (eoi || !is_digit) begin
      parse_phase     = SCAN_COLON;
      low_nibble_next = 1'b0;
      res = with_held(KIND_ERROR, '0, '0, ERR_NONHEX);
      return 1'b1;
    end
    if (!low_nibble_next) begin
      high_nib        = nib;
      low_nibble_next = 1'b1;
      return 1'b0;
    end
    low_nibble_next = 1'b0;
    val     = {high_nib, nib};
    run_sum = run_sum + val;

    // A whole byte is in; its meaning depends on its place in the record.
    case (parse_phase)
      GET_COUNT: begin
        count_seen  = val;
        parse_phase = GET_ADDR_HI;
      end
      GET_ADDR_HI: begin
        addr_seen   = {val, 8'h00};
        parse_phase = GET_ADDR_LO;
      end
      GET_ADDR_LO: begin
        addr_seen   = addr_seen | {8'h00, val};
        parse_phase = GET_TYPE;
      end
      GET_TYPE: begin
        type_seen   = val;
        parse_phase = (count_seen != 8'h00) ? GET_DATA : GET_SUM;
        res = with_held(KIND_HEADER, '0, '0, '0);
        return 1'b1;
      end
      GET_DATA: begin
        res = with_held(KIND_DATA, val, data_seen, '0);
        data_seen = data_seen + 8'd1;
        if (data_seen >= count_seen) begin
          parse_phase = GET_SUM;
        end
        return 1'b1;
      end
      default: begin
        parse_phase = SCAN_COLON;
        if (run_sum != 8'h00) begin
          res = with_held(KIND_ERROR, '0, '0, ERR_SUM);
        end else begin
          res = with_held(KIND_OK, '0, '0, '0);
        end
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Idle length: mostly none, sometimes a short gap, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Offers one character, waits for its transfer, records the expected result
  // and then idles for a random gap.
  task automatic put_char(input logic [7:0] ch, input logic eoi, input bit given = 1'b0,
                          input bit yields = 1'b0, input result_t want = NO_RESULT);
    result_t     pred;
    bit          due;
    int unsigned gap;
    in_character    <= ch;
    in_end_of_input <= eoi;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    chars_fed++;
    due = parse_char(ch, eoi, pred);
    if (given) begin
      if (yields) begin
        result_fifo.push_back(want);
      end
    end else if (due) begin
      result_fifo.push_back(pred);
    end
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the input off until every expected result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (result_fifo.size() != 0);
  endtask

  // Builds one random record and sends it, sometimes damaged on purpose.
  task automatic send_record();
    logic [7:0]  rec_bytes[$];
    logic [7:0]  chars[$];
    logic [7:0]  sum;
    logic [7:0]  bad;
    logic [3:0]  nib;
    int unsigned n_data;
    int unsigned roll;
    int          spot;
    int          eoi_spot;
    flaw_t       flaw;
    n_data = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
    rec_bytes.push_back(8'(n_data));
    rec_bytes.push_back(8'($urandom));
    rec_bytes.push_back(8'($urandom));
    rec_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)));
    repeat (n_data) rec_bytes.push_back(8'($urandom));
    sum = 8'h00;
    foreach (rec_bytes[i]) begin
      sum = sum + rec_bytes[i];
    end

    // Seven records in ten are clean.
    roll = $urandom_range(0, 9);
    flaw = (roll == 0) ? FLAW_SUM : (roll == 1) ? FLAW_CHAR : (roll == 2) ? FLAW_CUT : FLAW_NONE;
    if (flaw == FLAW_SUM) begin
      rec_bytes.push_back(8'h00 - sum + 8'($urandom_range(1, 255)));
    end else begin
      rec_bytes.push_back(8'h00 - sum);
    end

    chars.push_back(CH_COLON);
    foreach (rec_bytes[i]) begin
      chars.push_back(hex_digit(rec_bytes[i][7:4]));
      chars.push_back(hex_digit(rec_bytes[i][3:0]));
    end

    // A stray character is an end of input, a colon or any other non-digit.
    eoi_spot = -1;
    if (flaw == FLAW_CHAR) begin
      spot = $urandom_range(1, chars.size() - 1);
      if ($urandom_range(0, 3) == 0) begin
        eoi_spot = spot;
      end else if ($urandom_range(0, 2) == 0) begin
        chars[spot] = CH_COLON;
      end else begin
        do bad = 8'($urandom); while (hex_nibble(bad, nib));
        chars[spot] = bad;
      end
    end else if (flaw == FLAW_CUT) begin
      spot = $urandom_range(1, chars.size() - 2);
      while (chars.size() > spot) void'(chars.pop_back());
    end

    foreach (chars[i]) begin
      put_char(chars[i], i == eoi_spot);
    end
    record_chars += chars.size();
    records_sent++;
  endtask

  // Result side: check each output transfer, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        kind_seen[out_kind]++;
        if (result_fifo.size() == 0) begin
          $error("Unexpected result transfer: kind %0d", out_kind);
          fail_count++;
        end else begin
          head_result = result_fifo.pop_front();
          check_field("kind", head_result.kind, out_kind);
          check_field("address", head_result.address, out_address);
          check_field("record_type", head_result.record_type, out_record_type);
          check_field("byte_count", head_result.byte_count, out_byte_count);
          check_field("data_byte", head_result.data_byte, out_data_byte);
          check_field("data_index", head_result.data_index, out_data_index);
          check_field("error_code", head_result.error_code, out_error_code);
        end
      end

      // Alternate runs of taking and stalling.
      if (stall_run != 0) begin
        stall_run--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (out_stall) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(0, 8);
      end else begin
        out_stall <= 1'b1;
        stall_run = pick_gap();
      end
    end
  end

  // Main sequence.
  initial begin
    int unsigned rec_no;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < $size(directed_rows); i++) begin
      put_char(directed_rows[i].ch, directed_rows[i].eoi, directed_rows[i].given,
               directed_rows[i].yields, directed_rows[i].want);
    end

    // Random records with noise in between.
    rec_no = 0;
    while (record_chars < RANDOM_CHARS) begin
      rec_no++;
      calm = ((rec_no % 16) >= 13);
      if ((rec_no % 25) == 0) begin
        wait_for_results();
      end
      repeat (($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4)) begin
        put_char(8'($urandom), $urandom_range(0, 7) == 0);
      end
      send_record();
    end

    calm = 1'b0;
    wait_for_results();
    repeat (8) @(posedge clk);

    $display("Fed %0d characters, %0d random records, %0d results checked.",
             chars_fed, records_sent, results_seen);
    $display("Result mix: %0d headers, %0d data bytes, %0d good records, %0d errors.",
             kind_seen[KIND_HEADER], kind_seen[KIND_DATA], kind_seen[KIND_OK],
             kind_seen[KIND_ERROR]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Timeout with %0d results still expected.", result_fifo.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ihexp_pkg.sv
rtl/ihexp_engine.sv
rtl/intel_hex_record_parser_core.sv
rtl/ihexp_checker.sv
sim/tb_intel_hex_record_parser_core.sv
